@@ hw/rtl/ipc_rendezvous_engine_defines.svh @@
// Assertion macros shared by the rendezvous engine RTL.
// Depends on: a clock named aclk and an active-low reset named aresetn in scope.
`ifndef IPC_RENDEZVOUS_ENGINE_DEFINES_SVH
`define IPC_RENDEZVOUS_ENGINE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define IRE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that an event is followed by a property in the cycle after it.
`define IRE_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error(msg);

`endif

@@ hw/rtl/ire_pkg.sv @@
// Shared types and constants of the rendezvous engine.
// No dependencies.
package ire_pkg;

    localparam int NUM_PROCS    = 8;
    localparam int PID_W        = 3;
    localparam int PEER_W       = 4;
    localparam int PAYLOAD_BITS = 64;
    localparam int CNT_W        = $clog2(NUM_PROCS + 1);

    localparam logic [PEER_W-1:0] NUM_PROCS_P = PEER_W'(NUM_PROCS);
    localparam logic [PEER_W-1:0] PEER_ANY    = 4'd8;
    localparam logic [PEER_W-1:0] PEER_INTR   = 4'd9;
    localparam logic [PEER_W-1:0] NIL_LINK    = 4'd15;

    typedef enum logic [1:0] {
        CMD_SEND  = 2'd0,
        CMD_RECV  = 2'd1,
        CMD_RAISE = 2'd2,
        CMD_BAD   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DELIVERED = 2'd0,
        ST_BLOCKED   = 2'd1,
        ST_DEADLOCK  = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        WF_RUN  = 2'd0,
        WF_SEND = 2'd1,
        WF_RECV = 2'd2
    } wf_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_DECIDE,
        FS_WALK,
        FS_SEND,
        FS_UNLINK,
        FS_DONE
    } fsm_t;

    typedef struct packed {
        status_t                 status;
        logic [PID_W-1:0]        receiver_pid;
        logic [PEER_W-1:0]       source_code;
        logic [PAYLOAD_BITS-1:0] message;
        logic                    hard_interrupt;
        logic                    woken_valid;
        logic [PID_W-1:0]        woken_pid;
    } res_t;

    function automatic res_t res_plain(status_t st);
        res_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

endpackage

@@ hw/rtl/ire_msg_ram.sv @@
// Message store: one write port, one registered read port.
// No dependencies.
module ire_msg_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write a held payload
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, hold data between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/ipc_rendezvous_engine.sv @@
// Rendezvous engine: one operation (send, receive or raise interrupt) per input beat and
// one result beat per operation. A send walks the chain of blocked senders from its target
// one entry per cycle (up to NUM_PROCS entries), and a receive that takes a queued sender
// walks that receiver's sender queue one entry per cycle while the held payload is read
// from the message memory.
// Depends on: ire_pkg, ire_msg_ram, ipc_rendezvous_engine_defines.svh.
`include "ipc_rendezvous_engine_defines.svh"

module ipc_rendezvous_engine
    import ire_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // caller_pid, peer, payload, zero pad
    input  logic [1:0]  s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, receiver_pid, source_code, message, woken_valid, woken_pid, zero pad
    output logic [79:0] m_tdata,
    output logic        m_tuser   // hard_interrupt
);

    fsm_t state_reg, state_next;

    // Per-process state
    wf_t               wf_reg [NUM_PROCS];
    wf_t               wf_next[NUM_PROCS];
    logic [PID_W-1:0]  st_reg [NUM_PROCS];
    logic [PID_W-1:0]  st_next[NUM_PROCS];
    logic [PEER_W-1:0] rf_reg [NUM_PROCS];
    logic [PEER_W-1:0] rf_next[NUM_PROCS];
    logic              ip_reg [NUM_PROCS];
    logic              ip_next[NUM_PROCS];
    logic [PEER_W-1:0] qh_reg [NUM_PROCS];
    logic [PEER_W-1:0] qh_next[NUM_PROCS];
    logic [PEER_W-1:0] qt_reg [NUM_PROCS];
    logic [PEER_W-1:0] qt_next[NUM_PROCS];
    logic [PEER_W-1:0] qn_reg [NUM_PROCS];
    logic [PEER_W-1:0] qn_next[NUM_PROCS];

    // Operation in flight
    cmd_t                    cmd_reg;
    logic [PID_W-1:0]        me_reg;
    logic [PEER_W-1:0]       peer_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [PID_W-1:0]        from_reg, from_next;
    logic [PEER_W-1:0]       p_reg, p_next;
    logic [PEER_W-1:0]       prev_reg, prev_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    res_t                    res_reg, res_next;
    res_t                    m_res_reg;
    logic                    m_tvalid_reg;

    logic                    ram_we, ram_re;
    logic [PID_W-1:0]        ram_raddr;
    logic [PAYLOAD_BITS-1:0] ram_rdata;

    logic              accept, out_load;
    logic [PID_W-1:0]  peer_idx, walk_p, ul_p, head_idx;
    logic [PEER_W-1:0] me_p;
    logic              peer_pid, caller_bad, raise_hit, common_bad, send_bad, recv_bad;
    logic              recv_intr, any_hit, named_hit, from_hit;
    logic              walk_end, walk_hit, walk_last, ul_end, ul_hit, rcv_match;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == FS_IDLE);
    assign out_load = (state_reg == FS_DONE) && (!m_tvalid_reg || m_tready);

    // Decision terms
    assign me_p       = {1'b0, me_reg};
    assign peer_idx   = peer_reg[PID_W-1:0];
    assign peer_pid   = peer_reg < NUM_PROCS_P;
    assign caller_bad = (cmd_reg == CMD_BAD) || (me_p >= NUM_PROCS_P);
    assign raise_hit  = (wf_reg[me_reg] == WF_RECV)
                        && (rf_reg[me_reg] == PEER_ANY || rf_reg[me_reg] == PEER_INTR);
    assign common_bad = (peer_reg == me_p) || (wf_reg[me_reg] != WF_RUN);
    assign send_bad   = !peer_pid;
    assign recv_bad   = (peer_reg > PEER_INTR)
                        || (peer_reg != PEER_ANY && peer_reg != PEER_INTR && !peer_pid);
    assign recv_intr  = ip_reg[me_reg] && (peer_reg == PEER_ANY || peer_reg == PEER_INTR);
    assign head_idx   = qh_reg[me_reg][PID_W-1:0];
    assign any_hit    = (peer_reg == PEER_ANY) && (qh_reg[me_reg] < NUM_PROCS_P);
    assign named_hit  = peer_pid && (wf_reg[peer_idx] == WF_SEND)
                        && (st_reg[peer_idx] == me_reg);
    assign from_hit   = any_hit || named_hit;
    assign walk_p     = p_reg[PID_W-1:0];
    assign walk_end   = (p_reg >= NUM_PROCS_P) || (wf_reg[walk_p] != WF_SEND);
    assign walk_hit   = (st_reg[walk_p] == me_reg);
    assign walk_last  = (cnt_reg == CNT_W'(NUM_PROCS - 1));
    assign ul_p       = p_reg[PID_W-1:0];
    assign ul_end     = (cnt_reg == CNT_W'(NUM_PROCS)) || (p_reg >= NUM_PROCS_P);
    assign ul_hit     = (p_reg == {1'b0, from_reg});
    assign rcv_match  = (wf_reg[peer_idx] == WF_RECV)
                        && (rf_reg[peer_idx] == me_p || rf_reg[peer_idx] == PEER_ANY);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE: begin
                if (accept) state_next = FS_DECIDE;
            end
            FS_DECIDE: begin
                if (caller_bad || cmd_reg == CMD_RAISE || common_bad) begin
                    state_next = FS_DONE;
                end else if (cmd_reg == CMD_SEND) begin
                    state_next = send_bad ? FS_DONE : FS_WALK;
                end else if (recv_bad || recv_intr || !from_hit) begin
                    state_next = FS_DONE;
                end else begin
                    state_next = FS_UNLINK;
                end
            end
            FS_WALK: begin
                if (walk_end) state_next = FS_SEND;
                else if (walk_hit) state_next = FS_DONE;
                else if (walk_last) state_next = FS_SEND;
            end
            FS_SEND: state_next = FS_DONE;
            FS_UNLINK: begin
                if (ul_end || ul_hit) state_next = FS_DONE;
            end
            FS_DONE: begin
                if (out_load) state_next = FS_IDLE;
            end
            default: state_next = FS_IDLE;
        endcase
    end

    // Datapath: read, modify and write back the process state
    always_comb begin
        wf_next   = wf_reg;
        st_next   = st_reg;
        rf_next   = rf_reg;
        ip_next   = ip_reg;
        qh_next   = qh_reg;
        qt_next   = qt_reg;
        qn_next   = qn_reg;
        from_next = from_reg;
        p_next    = p_reg;
        prev_next = prev_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = from_reg;
        case (state_reg)
            FS_DECIDE: begin
                if (caller_bad) begin
                    res_next = res_plain(ST_INVALID);
                end else if (cmd_reg == CMD_RAISE) begin
                    if (raise_hit) begin
                        wf_next[me_reg] = WF_RUN;
                        rf_next[me_reg] = '0;
                        ip_next[me_reg] = 1'b0;
                        res_next                = res_plain(ST_DELIVERED);
                        res_next.receiver_pid   = me_reg;
                        res_next.source_code    = PEER_INTR;
                        res_next.hard_interrupt = 1'b1;
                        res_next.woken_valid    = 1'b1;
                        res_next.woken_pid      = me_reg;
                    end else begin
                        ip_next[me_reg] = 1'b1;
                        res_next        = res_plain(ST_BLOCKED);
                    end
                end else if (common_bad) begin
                    res_next = res_plain(ST_INVALID);
                end else if (cmd_reg == CMD_SEND) begin
                    res_next = res_plain(ST_INVALID);
                    p_next   = peer_reg;
                    cnt_next = '0;
                end else if (recv_bad) begin
                    res_next = res_plain(ST_INVALID);
                end else if (recv_intr) begin
                    ip_next[me_reg]         = 1'b0;
                    res_next                = res_plain(ST_DELIVERED);
                    res_next.receiver_pid   = me_reg;
                    res_next.source_code    = PEER_INTR;
                    res_next.hard_interrupt = 1'b1;
                end else if (from_hit) begin
                    // fetch the held payload while the queue is walked
                    from_next = any_hit ? head_idx : peer_idx;
                    ram_re    = 1'b1;
                    ram_raddr = any_hit ? head_idx : peer_idx;
                    p_next    = qh_reg[me_reg];
                    prev_next = NIL_LINK;
                    cnt_next  = '0;
                end else begin
                    wf_next[me_reg] = WF_RECV;
                    rf_next[me_reg] = peer_reg;
                    res_next        = res_plain(ST_BLOCKED);
                end
            end
            FS_WALK: begin
                if (!walk_end && walk_hit) begin
                    res_next = res_plain(ST_DEADLOCK);
                end else if (!walk_end) begin
                    p_next   = {1'b0, st_reg[walk_p]};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            FS_SEND: begin
                if (rcv_match) begin
                    wf_next[peer_idx]     = WF_RUN;
                    rf_next[peer_idx]     = '0;
                    res_next              = res_plain(ST_DELIVERED);
                    res_next.receiver_pid = peer_idx;
                    res_next.source_code  = me_p;
                    res_next.message      = pay_reg;
                    res_next.woken_valid  = 1'b1;
                    res_next.woken_pid    = peer_idx;
                end else begin
                    // block the sender at the tail of the target's queue
                    wf_next[me_reg] = WF_SEND;
                    st_next[me_reg] = peer_idx;
                    ram_we          = 1'b1;
                    qn_next[me_reg] = NIL_LINK;
                    if (qh_reg[peer_idx] >= NUM_PROCS_P || qt_reg[peer_idx] >= NUM_PROCS_P) begin
                        qh_next[peer_idx] = me_p;
                    end else begin
                        qn_next[qt_reg[peer_idx][PID_W-1:0]] = me_p;
                    end
                    qt_next[peer_idx] = me_p;
                    res_next          = res_plain(ST_BLOCKED);
                end
            end
            FS_UNLINK: begin
                if (ul_end || ul_hit) begin
                    if (!ul_end) begin
                        if (prev_reg == NIL_LINK) begin
                            qh_next[me_reg] = qn_reg[ul_p];
                        end else begin
                            qn_next[prev_reg[PID_W-1:0]] = qn_reg[ul_p];
                        end
                        if (qt_reg[me_reg] == {1'b0, from_reg}) begin
                            qt_next[me_reg] = prev_reg;
                        end
                        qn_next[ul_p] = NIL_LINK;
                    end
                    wf_next[from_reg]     = WF_RUN;
                    st_next[from_reg]     = '0;
                    res_next              = res_plain(ST_DELIVERED);
                    res_next.receiver_pid = me_reg;
                    res_next.source_code  = {1'b0, from_reg};
                    res_next.message      = ram_rdata;
                    res_next.woken_valid  = 1'b1;
                    res_next.woken_pid    = from_reg;
                end else begin
                    prev_next = p_reg;
                    p_next    = qn_reg[ul_p];
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers and process state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FS_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_PROCS; i++) begin
                wf_reg[i] <= WF_RUN;
                st_reg[i] <= '0;
                rf_reg[i] <= '0;
                ip_reg[i] <= 1'b0;
                qh_reg[i] <= NIL_LINK;
                qt_reg[i] <= NIL_LINK;
                qn_reg[i] <= NIL_LINK;
            end
        end else begin
            state_reg <= state_next;
            wf_reg    <= wf_next;
            st_reg    <= st_next;
            rf_reg    <= rf_next;
            ip_reg    <= ip_next;
            qh_reg    <= qh_next;
            qt_reg    <= qt_next;
            qn_reg    <= qn_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Operation and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= cmd_t'(s_tuser);
            me_reg   <= s_tdata[2:0];
            peer_reg <= s_tdata[6:3];
            pay_reg  <= s_tdata[70:7];
        end
        from_reg <= from_next;
        p_reg    <= p_next;
        prev_reg <= prev_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        if (out_load) begin
            m_res_reg <= res_reg;
        end
    end

    ire_msg_ram #(
        .DEPTH(NUM_PROCS),
        .WIDTH(PAYLOAD_BITS)
    ) u_msg_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (me_reg),
        .wdata (pay_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.hard_interrupt;
    assign m_tdata  = {3'b000, m_res_reg.woken_pid, m_res_reg.woken_valid, m_res_reg.message,
                       m_res_reg.source_code, m_res_reg.receiver_pid, m_res_reg.status};

    `IRE_ASSERT(a_walk_bound, (state_reg == FS_WALK) |-> (cnt_reg < CNT_W'(NUM_PROCS)), "chain walk overran")
    `IRE_ASSERT_NEXT(a_accept_busy, accept, state_reg == FS_DECIDE, "accepted beat not decoded")
    `IRE_ASSERT(a_refused_quiet, (m_tvalid && m_res_reg.status != ST_DELIVERED) |-> !m_res_reg.woken_valid, "wake on a refused operation")

endmodule

@@ tb/ipc_rendezvous_checker.sv @@
// Checker for the rendezvous engine: watches both stream channels, predicts each
// result beat from its own copy of the process table and compares field by field.
// Depends on: ire_pkg.
module ipc_rendezvous_checker
    import ire_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t     status;
        logic [2:0]  receiver_pid;
        logic [3:0]  source_code;
        logic [63:0] message;
        logic        hard_interrupt;
        logic        woken_valid;
        logic [2:0]  woken_pid;
    } outcome_t;

    // Shadow process table
    wf_t         flags_q   [NUM_PROCS];
    logic [3:0]  dest_q    [NUM_PROCS];
    logic [3:0]  src_q     [NUM_PROCS];
    logic [63:0] held_q    [NUM_PROCS];
    logic        irq_q     [NUM_PROCS];
    logic [3:0]  head_q    [NUM_PROCS];
    logic [3:0]  tail_q    [NUM_PROCS];
    logic [3:0]  link_q    [NUM_PROCS];

    outcome_t expected_results[$];

    function automatic outcome_t plain(status_t st);
        outcome_t o;
        o = '{st, 3'd0, 4'd0, 64'd0, 1'b0, 1'b0, 3'd0};
        return o;
    endfunction

    function automatic bit closes_cycle(int me, int dst);
        int p;
        p = dst;
        for (int n = 0; n < NUM_PROCS; n++) begin
            if (p >= NUM_PROCS || flags_q[p] != WF_SEND) return 0;
            if (dest_q[p] == me) return 1;
            p = dest_q[p];
        end
        return 0;
    endfunction

    function automatic void remove_sender(int rcv, int s);
        int prv, p;
        prv = NIL_LINK;
        p   = head_q[rcv];
        for (int n = 0; n < NUM_PROCS && p < NUM_PROCS; n++) begin
            if (p == s) begin
                if (prv == NIL_LINK) head_q[rcv] = link_q[p];
                else link_q[prv] = link_q[p];
                if (tail_q[rcv] == s) tail_q[rcv] = 4'(prv);
                link_q[p] = NIL_LINK;
                return;
            end
            prv = p;
            p   = link_q[p];
        end
    endfunction

    // Advance the process table by one operation and return its outcome
    function automatic outcome_t rendezvous(cmd_t cmd, int me, int peer, logic [63:0] pay);
        outcome_t o;
        int from;
        if (cmd == CMD_BAD || me >= NUM_PROCS) return plain(ST_INVALID);
        if (cmd == CMD_RAISE) begin
            if (flags_q[me] == WF_RECV && (src_q[me] == PEER_ANY || src_q[me] == PEER_INTR)) begin
                flags_q[me] = WF_RUN;
                src_q[me]   = 0;
                irq_q[me]   = 0;
                o = '{ST_DELIVERED, me[2:0], PEER_INTR, 64'd0, 1'b1, 1'b1, me[2:0]};
                return o;
            end
            irq_q[me] = 1;
            return plain(ST_BLOCKED);
        end
        if (peer == me || flags_q[me] != WF_RUN) return plain(ST_INVALID);
        if (cmd == CMD_SEND) begin
            if (peer >= NUM_PROCS) return plain(ST_INVALID);
            if (closes_cycle(me, peer)) return plain(ST_DEADLOCK);
            if (flags_q[peer] == WF_RECV && (src_q[peer] == me || src_q[peer] == PEER_ANY)) begin
                flags_q[peer] = WF_RUN;
                src_q[peer]   = 0;
                o = '{ST_DELIVERED, peer[2:0], me[3:0], pay, 1'b0, 1'b1, peer[2:0]};
                return o;
            end
            flags_q[me] = WF_SEND;
            dest_q[me]  = 4'(peer);
            held_q[me]  = pay;
            link_q[me]  = NIL_LINK;
            if (head_q[peer] >= NUM_PROCS || tail_q[peer] >= NUM_PROCS) head_q[peer] = 4'(me);
            else link_q[tail_q[peer]] = 4'(me);
            tail_q[peer] = 4'(me);
            return plain(ST_BLOCKED);
        end
        // receive
        if (peer > PEER_INTR) return plain(ST_INVALID);
        if (irq_q[me] && (peer == PEER_ANY || peer == PEER_INTR)) begin
            irq_q[me] = 0;
            o = '{ST_DELIVERED, me[2:0], PEER_INTR, 64'd0, 1'b1, 1'b0, 3'd0};
            return o;
        end
        from = NIL_LINK;
        if (peer == PEER_ANY) begin
            if (head_q[me] < NUM_PROCS) from = head_q[me];
        end else if (peer != PEER_INTR) begin
            if (flags_q[peer] == WF_SEND && dest_q[peer] == me) from = peer;
        end
        if (from < NUM_PROCS) begin
            o = '{ST_DELIVERED, me[2:0], from[3:0], held_q[from], 1'b0, 1'b1, from[2:0]};
            remove_sender(me, from);
            flags_q[from] = WF_RUN;
            dest_q[from]  = 0;
            return o;
        end
        flags_q[me] = WF_RECV;
        src_q[me]   = 4'(peer);
        return plain(ST_BLOCKED);
    endfunction

    // Predict on input beats, compare on result beats
    always @(posedge aclk) begin
        outcome_t exp_o, got;
        if (!aresetn) begin
            for (int i = 0; i < NUM_PROCS; i++) begin
                flags_q[i] = WF_RUN;
                dest_q[i]  = 0;
                src_q[i]   = 0;
                held_q[i]  = 0;
                irq_q[i]   = 0;
                head_q[i]  = NIL_LINK;
                tail_q[i]  = NIL_LINK;
                link_q[i]  = NIL_LINK;
            end
            expected_results.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(rendezvous(cmd_t'(s_tuser), int'(s_tdata[2:0]),
                                                      int'(s_tdata[6:3]), s_tdata[70:7]));
            if (m_tvalid && m_tready) begin
                got.status         = status_t'(m_tdata[1:0]);
                got.receiver_pid   = m_tdata[4:2];
                got.source_code    = m_tdata[8:5];
                got.message        = m_tdata[72:9];
                got.woken_valid    = m_tdata[73];
                got.woken_pid      = m_tdata[76:74];
                got.hard_interrupt = m_tuser;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat: %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_o = expected_results.pop_front();
                    if (got !== exp_o) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", exp_o, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_results.size();
        end
    end
endmodule

@@ tb/tb_top.sv @@
// Testbench top for the rendezvous engine: clock, reset, stimulus and verdict.
// Depends on: ire_pkg, ipc_rendezvous_engine, ipc_rendezvous_checker.
module tb_top;
    import ire_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending_count;
    int          cycles = 0;
    int          hold_off = 0;
    bit          long_hold_done = 0;

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    ipc_rendezvous_engine i_dut (.*);

    ipc_rendezvous_checker i_checker (.*);

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Receiver: stall pattern, with one long hold-off while the sender keeps offering
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end else if (!long_hold_done && cycles == 3000) begin
            long_hold_done <= 1;
            hold_off <= 400;
            m_tready <= 0;
        end else if (cycles[9]) begin
            m_tready <= 1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_op(cmd_t cmd, logic [2:0] me, logic [3:0] peer, logic [63:0] pay);
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, pay, peer, me};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_gap();
        int gap;
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Mostly meaningful operations: sends and receives among valid pids, interrupt raises, some noise
    task automatic random_op();
        int r;
        logic [2:0] me;
        logic [3:0] peer;
        logic [63:0] pay;
        r    = $urandom_range(0, 99);
        me   = 3'($urandom_range(0, 7));
        pay  = {$urandom, $urandom};
        if (r < 42) send_op(CMD_SEND, me, 4'($urandom_range(0, 7)), pay);
        else if (r < 80) begin
            peer = ($urandom_range(0, 2) == 0) ? PEER_ANY : 4'($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0) peer = PEER_INTR;
            send_op(CMD_RECV, me, peer, pay);
        end else if (r < 90) send_op(CMD_RAISE, me, 4'($urandom), pay);
        else send_op(cmd_t'($urandom_range(0, 3)), me, 4'($urandom), pay);
    endtask

    initial begin
        int burst;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: invalid forms, extremes, deadlock, interrupts, named and any receive
        send_op(CMD_BAD, 3'd0, 4'd1, 64'h0);
        send_op(CMD_SEND, 3'd2, 4'd2, 64'h0);
        send_op(CMD_SEND, 3'd2, PEER_ANY, 64'h0);
        send_op(CMD_SEND, 3'd2, PEER_INTR, 64'h0);
        send_op(CMD_RECV, 3'd2, 4'd15, 64'h0);
        send_op(CMD_RECV, 3'd2, 4'd10, 64'h0);
        send_op(CMD_SEND, 3'd0, 4'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(CMD_SEND, 3'd0, 4'd6, 64'h1);
        send_op(CMD_SEND, 3'd7, 4'd0, 64'h5555_AAAA_5555_AAAA);
        send_op(CMD_SEND, 3'd1, 4'd7, 64'hAAAA_5555_AAAA_5555);
        send_op(CMD_RECV, 3'd7, 4'd1, 64'h0);
        send_op(CMD_RECV, 3'd7, PEER_ANY, 64'h0);
        send_op(CMD_RECV, 3'd0, PEER_ANY, 64'h0);
        send_op(CMD_RECV, 3'd5, PEER_INTR, 64'h0);
        send_op(CMD_RECV, 3'd5, PEER_ANY, 64'h0);
        send_op(CMD_RAISE, 3'd5, 4'd15, 64'hDEAD);
        send_op(CMD_RAISE, 3'd4, 4'd0, 64'h0);
        send_op(CMD_RECV, 3'd4, PEER_INTR, 64'h0);
        send_op(CMD_RAISE, 3'd4, 4'd0, 64'h0);
        send_op(CMD_RECV, 3'd4, PEER_ANY, 64'h0);
        send_op(CMD_RECV, 3'd6, 4'd3, 64'h0);
        send_op(CMD_SEND, 3'd3, 4'd6, 64'h0123_4567_89AB_CDEF);
        send_op(CMD_RAISE, 3'd7, 4'd0, 64'h0);

        // Random bursts with gaps
        for (int n = 0; n < 1400; n += burst) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++) random_op();
            idle_gap();
        end
        s_tvalid <= 0;

        // let the checker count the last accepted beat before draining
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

@@ ipc_rendezvous_engine.f @@
+incdir+hw/rtl
hw/rtl/ire_pkg.sv
hw/rtl/ire_msg_ram.sv
hw/rtl/ipc_rendezvous_engine.sv
tb/ipc_rendezvous_checker.sv
tb/tb_top.sv
